>>> sv/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder package
// Shared types, register codes, constant tables and the color wheel function.
// ----------------------------------------------------------------------------
package lsbe_pkg;

	localparam int COLOR_W = 24;
	localparam int DUTY_W  = 8;
	localparam int STEP_W  = 11;
	localparam int PHASE_W = 2;
	localparam int PIX_W   = 6;
	localparam int MODE_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_CODES = 1 << PIX_W;

	localparam logic [MODE_W-1:0] MODE_WIPE        = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RAINBOW     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CYCLE       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHASE       = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CHASE_RB    = 3'd4;

	localparam logic [COLOR_W-1:0] MSB_MASK = 24'h800000;
	localparam logic [7:0] WHEEL_THIRD     = 8'd85;
	localparam logic [7:0] WHEEL_TWO_THIRD = 8'd170;
	localparam logic [7:0] WHEEL_FULL      = 8'd255;

	localparam logic [MODE_W-1:0]  RST_EFFECT_MODE = 3'd0;
	localparam logic [COLOR_W-1:0] RST_BASE_COLOR  = 24'd0;
	localparam logic [DUTY_W-1:0]  RST_ONE_DUTY    = 8'd60;
	localparam logic [DUTY_W-1:0]  RST_ZERO_DUTY   = 8'd30;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EFFECT_MODE = 2'd0,
		REG_BASE_COLOR  = 2'd1,
		REG_ONE_DUTY    = 2'd2,
		REG_ZERO_DUTY   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0]  effect_mode;
		logic [COLOR_W-1:0] base_color;
		logic [DUTY_W-1:0]  one_duty;
		logic [DUTY_W-1:0]  zero_duty;
	} cfg_t;

	typedef struct packed {
		logic               push;
		logic [COLOR_W-1:0] color;
	} q_wr_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [COLOR_W-1:0] head;
	} q_stat_t;

	typedef logic [1:0] mod3_tbl_t [PIX_CODES];

	function automatic mod3_tbl_t mk_mod3_tbl();
		mod3_tbl_t t;
		for (int i = 0; i < PIX_CODES; i++) begin
			t[i] = 2'(i % 3);
		end
		return t;
	endfunction

	localparam mod3_tbl_t MOD3_TBL = mk_mod3_tbl();

	function automatic logic [COLOR_W-1:0] pack_grb(logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		return {g, r, b};
	endfunction

	function automatic logic [COLOR_W-1:0] wheel(logic [7:0] w);
		logic [7:0] v;
		logic [7:0] u;
		logic [7:0] u3;
		logic [COLOR_W-1:0] c;
		v = WHEEL_FULL - w;
		if (v < WHEEL_THIRD) begin
			u = v;
		end else if (v < WHEEL_TWO_THIRD) begin
			u = v - WHEEL_THIRD;
		end else begin
			u = v - WHEEL_TWO_THIRD;
		end
		u3 = 8'({u, 1'b0}) + u;
		if (v < WHEEL_THIRD) begin
			c = pack_grb(WHEEL_FULL - u3, 8'd0, u3);
		end else if (v < WHEEL_TWO_THIRD) begin
			c = pack_grb(8'd0, u3, WHEEL_FULL - u3);
		end else begin
			c = pack_grb(u3, WHEEL_FULL - u3, 8'd0);
		end
		return c;
	endfunction

endpackage

>>> sv/lsbe_if.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder channels
// Valid/ready channels for pixel items, bit-slot results and register writes.
// ----------------------------------------------------------------------------
interface lsbe_pix_if;
	logic                         valid;
	logic                         ready;
	logic [lsbe_pkg::STEP_W-1:0]  frame_step;
	logic [lsbe_pkg::PHASE_W-1:0] chase_phase;
	logic [lsbe_pkg::PIX_W-1:0]   pixel_index;

	modport source (output valid, frame_step, chase_phase, pixel_index, input ready);
	modport sink (input valid, frame_step, chase_phase, pixel_index, output ready);
endinterface

interface lsbe_bits_if;
	logic                         valid;
	logic                         ready;
	logic [lsbe_pkg::DUTY_W-1:0]  duty;
	logic                         last_bit;
	logic [lsbe_pkg::COLOR_W-1:0] pixel_color;

	modport source (output valid, duty, last_bit, pixel_color, input ready);
	modport sink (input valid, duty, last_bit, pixel_color, output ready);
endinterface

interface lsbe_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lsbe_pkg::CFG_IDX_W-1:0] index;
	logic [lsbe_pkg::COLOR_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/lsbe_front.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder front end
// Accepts pixel items, classifies them by effect mode and resolves the color.
// ----------------------------------------------------------------------------
module lsbe_front #(
	parameter int PIXELS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	lsbe_pix_if.sink            pix,
	input  lsbe_pkg::cfg_t      cfg,
	input  lsbe_pkg::q_stat_t   q_stat,
	output lsbe_pkg::q_wr_t     q_wr
);

	typedef enum logic [1:0] {
		KIND_ZERO,
		KIND_BASE,
		KIND_WHEEL
	} kind_t;

	typedef logic [7:0] cyc_tbl_t [lsbe_pkg::PIX_CODES];

	function automatic cyc_tbl_t mk_cyc_tbl();
		cyc_tbl_t t;
		for (int i = 0; i < lsbe_pkg::PIX_CODES; i++) begin
			t[i] = 8'((i * 256) / PIXELS);
		end
		return t;
	endfunction

	localparam cyc_tbl_t CYC_TBL = mk_cyc_tbl();

	logic       valid_s1;
	kind_t      kind_s1;
	logic [7:0] wpos_s1;

	logic       accept;
	logic       in_range;
	logic       phase_hit;
	kind_t      kind_d;
	logic [7:0] wpos_d;
	logic [11:0] chase_sum;
	logic [8:0]  fold_sum;

	assign pix.ready = !valid_s1 || !q_stat.full;
	assign accept    = pix.valid && pix.ready;
	assign in_range  = int'(pix.pixel_index) < PIXELS;
	assign phase_hit = {1'b0, lsbe_pkg::MOD3_TBL[pix.pixel_index]} == {1'b0, pix.chase_phase};

	// 256 is 1 modulo 255, so folding the high nibble onto the low byte leaves
	// a value below twice the modulus.
	assign chase_sum = 12'(pix.frame_step) + 12'(pix.pixel_index) - 12'(pix.chase_phase);
	assign fold_sum  = 9'(chase_sum[11:8]) + 9'(chase_sum[7:0]);

	always_comb begin
		kind_d = KIND_ZERO;
		wpos_d = 8'd0;
		case (cfg.effect_mode)
			lsbe_pkg::MODE_WIPE: begin
				kind_d = (11'(pix.pixel_index) <= pix.frame_step) ? KIND_BASE : KIND_ZERO;
			end
			lsbe_pkg::MODE_RAINBOW: begin
				kind_d = KIND_WHEEL;
				wpos_d = 8'(pix.pixel_index) + pix.frame_step[7:0];
			end
			lsbe_pkg::MODE_CYCLE: begin
				kind_d = KIND_WHEEL;
				wpos_d = CYC_TBL[pix.pixel_index] + pix.frame_step[7:0];
			end
			lsbe_pkg::MODE_CHASE: begin
				kind_d = phase_hit ? KIND_BASE : KIND_ZERO;
			end
			lsbe_pkg::MODE_CHASE_RB: begin
				kind_d = phase_hit ? KIND_WHEEL : KIND_ZERO;
				wpos_d = (fold_sum >= 9'(lsbe_pkg::WHEEL_FULL))
					? 8'(fold_sum - 9'(lsbe_pkg::WHEEL_FULL)) : fold_sum[7:0];
			end
			default: begin
				kind_d = KIND_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix.ready) begin
			valid_s1 <= accept && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_d;
			wpos_s1 <= wpos_d;
		end
	end

	always_comb begin
		q_wr.push = valid_s1 && !q_stat.full;
		case (kind_s1)
			KIND_BASE:  q_wr.color = cfg.base_color;
			KIND_WHEEL: q_wr.color = lsbe_pkg::wheel(wpos_s1);
			default:    q_wr.color = '0;
		endcase
	end

endmodule

>>> sv/lsbe_queue.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder color queue
// Two-entry queue of resolved pixel colors between front end and serializer.
// ----------------------------------------------------------------------------
module lsbe_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  lsbe_pkg::q_wr_t   q_wr,
	input  logic              pop,
	output lsbe_pkg::q_stat_t q_stat
);

	logic [lsbe_pkg::COLOR_W-1:0] mem_q [2];
	logic                         wr_ptr_q;
	logic                         rd_ptr_q;
	logic [1:0]                   count_q;
	logic                         do_pop;

	assign q_stat.full  = count_q == 2'd2;
	assign q_stat.empty = count_q == 2'd0;
	assign q_stat.head  = mem_q[rd_ptr_q];
	assign do_pop       = pop && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(q_wr.push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wr_ptr_q] <= q_wr.color;
		end
	end

endmodule

>>> sv/lsbe_back.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder serializer
// Turns each queued color into 24 bit-slot results, most significant first.
// ----------------------------------------------------------------------------
module lsbe_back (
	input  logic              clk,
	input  logic              arst_n,
	input  lsbe_pkg::cfg_t    cfg,
	input  lsbe_pkg::q_stat_t q_stat,
	output logic              pop,
	lsbe_bits_if.source       bits
);

	logic                         out_valid_q;
	logic [lsbe_pkg::DUTY_W-1:0]  duty_q;
	logic                         last_q;
	logic [lsbe_pkg::COLOR_W-1:0] color_q;
	logic [lsbe_pkg::COLOR_W-1:0] shift_q;
	logic [4:0]                   remain_q;

	logic load;
	logic busy;

	assign load = !out_valid_q || bits.ready;
	assign busy = remain_q != 5'd0;
	assign pop  = load && !busy && !q_stat.empty;

	assign bits.valid       = out_valid_q;
	assign bits.duty        = duty_q;
	assign bits.last_bit    = last_q;
	assign bits.pixel_color = color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			remain_q    <= 5'd0;
		end else if (load) begin
			if (busy) begin
				out_valid_q <= 1'b1;
				remain_q    <= remain_q - 5'd1;
			end else if (!q_stat.empty) begin
				out_valid_q <= 1'b1;
				remain_q    <= 5'(lsbe_pkg::COLOR_W - 1);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (busy) begin
				duty_q  <= ((shift_q & lsbe_pkg::MSB_MASK) != '0) ? cfg.one_duty : cfg.zero_duty;
				last_q  <= remain_q == 5'd1;
				shift_q <= shift_q << 1;
			end else if (!q_stat.empty) begin
				duty_q  <= ((q_stat.head & lsbe_pkg::MSB_MASK) != '0)
					? cfg.one_duty : cfg.zero_duty;
				last_q  <= 1'b0;
				color_q <= q_stat.head;
				shift_q <= q_stat.head << 1;
			end
		end
	end

endmodule

>>> sv/led_strip_effect_bit_encoder_top.sv
// ----------------------------------------------------------------------------
// LED strip effect bit encoder top level
// Computes one pixel color per item and emits its 24 bit-slot compare values.
// ----------------------------------------------------------------------------
// Usage: pixel items enter on the pix channel, each naming a frame step, a
// chase phase and a pixel index. For every pixel inside the strip the bits
// channel carries 24 transfers, one per color bit from the most significant
// down, each with the duty value for that bit, the full color and a last-bit
// flag on the final slot. Pixels at or beyond PIXELS produce no transfers.
// Registers are written over the cfg channel, which is always ready; write
// them only while the block is idle.
// A pixel's first bit slot passes the front-end stage register, the color
// queue and the serializer output register before it is presented. The
// serializer emits one bit slot per cycle while the receiver is ready; a
// two-entry color queue lets the front end take the next pixels while a pixel is still being sent.
// When the receiver stalls, the current slot holds and the front end keeps
// accepting until the queue fills. Reset empties the queue and loads the
// register reset values (wipe mode, black, duties 60 and 30).
// ----------------------------------------------------------------------------
module led_strip_effect_bit_encoder_top #(
	parameter int PIXELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	lsbe_pix_if.sink    pix,
	lsbe_bits_if.source bits,
	lsbe_cfg_if.sink    cfg
);

	lsbe_pkg::cfg_t    cfg_q;
	lsbe_pkg::q_wr_t   q_wr;
	lsbe_pkg::q_stat_t q_stat;
	logic              pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.effect_mode <= lsbe_pkg::RST_EFFECT_MODE;
			cfg_q.base_color  <= lsbe_pkg::RST_BASE_COLOR;
			cfg_q.one_duty    <= lsbe_pkg::RST_ONE_DUTY;
			cfg_q.zero_duty   <= lsbe_pkg::RST_ZERO_DUTY;
		end else if (cfg.valid) begin
			unique case (lsbe_pkg::reg_idx_t'(cfg.index))
				lsbe_pkg::REG_EFFECT_MODE: cfg_q.effect_mode <= cfg.data[lsbe_pkg::MODE_W-1:0];
				lsbe_pkg::REG_BASE_COLOR:  cfg_q.base_color  <= cfg.data;
				lsbe_pkg::REG_ONE_DUTY:    cfg_q.one_duty    <= cfg.data[lsbe_pkg::DUTY_W-1:0];
				lsbe_pkg::REG_ZERO_DUTY:   cfg_q.zero_duty   <= cfg.data[lsbe_pkg::DUTY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lsbe_front #(
		.PIXELS (PIXELS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.q_wr   (q_wr)
	);

	lsbe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_stat (q_stat)
	);

	lsbe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_stat (q_stat),
		.pop    (pop),
		.bits   (bits)
	);

endmodule

>>> tb/led_strip_effect_bit_encoder_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip effect bit encoder testbench
// Drives pixel items and register writes into the encoder. A local color
// predictor turns every accepted pixel into its 24 expected bit slots. Each
// bit-slot transfer is checked against the oldest of them. Directed tests
// cover every effect, the field extremes, chase phase three and the unused
// modes. A random part then runs under four mixes of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module led_strip_effect_bit_encoder_top_tb;

	localparam int STRIP_LEN   = 64;
	localparam int SLOTS       = 24;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic [lsbe_pkg::DUTY_W-1:0]  duty;
		logic                         last_bit;
		logic [lsbe_pkg::COLOR_W-1:0] color;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n;

	lsbe_pix_if  pix ();
	lsbe_bits_if bits ();
	lsbe_cfg_if  cfg ();

	led_strip_effect_bit_encoder_top #(
		.PIXELS(STRIP_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.bits(bits),
		.cfg(cfg)
	);

	logic [lsbe_pkg::MODE_W-1:0]  cur_mode = lsbe_pkg::RST_EFFECT_MODE;
	logic [lsbe_pkg::COLOR_W-1:0] cur_base = lsbe_pkg::RST_BASE_COLOR;
	logic [lsbe_pkg::DUTY_W-1:0]  cur_one  = lsbe_pkg::RST_ONE_DUTY;
	logic [lsbe_pkg::DUTY_W-1:0]  cur_zero = lsbe_pkg::RST_ZERO_DUTY;

	slot_t pending_slots[$];
	slot_t got_slot;
	slot_t want_slot;
	logic [lsbe_pkg::COLOR_W-1:0] pix_color;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int pixels_accepted = 0;
	int slots_checked = 0;
	int settings_loaded = 0;
	int cycle_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [lsbe_pkg::COLOR_W-1:0] hue_to_grb(input int pos);
		int v;
		int u;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		v = 255 - (pos & 255);
		if (v < 85) begin
			r = 8'(255 - 3 * v);
			g = 8'd0;
			b = 8'(3 * v);
		end else if (v < 170) begin
			u = v - 85;
			r = 8'd0;
			g = 8'(3 * u);
			b = 8'(255 - 3 * u);
		end else begin
			u = v - 170;
			r = 8'(3 * u);
			g = 8'(255 - 3 * u);
			b = 8'd0;
		end
		return {g, r, b};
	endfunction

	function automatic logic [lsbe_pkg::COLOR_W-1:0] expected_grb(
			input logic [lsbe_pkg::STEP_W-1:0] step,
			input logic [lsbe_pkg::PHASE_W-1:0] phase,
			input logic [lsbe_pkg::PIX_W-1:0] index);
		int j;
		int q;
		int p;
		j = int'(step);
		q = int'(phase);
		p = int'(index);
		case (cur_mode)
			lsbe_pkg::MODE_WIPE: return (p <= j) ? cur_base : '0;
			lsbe_pkg::MODE_RAINBOW: return hue_to_grb((p + j) & 255);
			lsbe_pkg::MODE_CYCLE: return hue_to_grb((p * 256 / STRIP_LEN + j) & 255);
			lsbe_pkg::MODE_CHASE: return (p % 3 == q) ? cur_base : '0;
			lsbe_pkg::MODE_CHASE_RB: begin
				if (p % 3 != q) begin
					return '0;
				end
				return hue_to_grb((p - q + j) % 255);
			end
			default: return '0;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					lsbe_pkg::REG_EFFECT_MODE: cur_mode = cfg.data[lsbe_pkg::MODE_W-1:0];
					lsbe_pkg::REG_BASE_COLOR: cur_base = cfg.data[lsbe_pkg::COLOR_W-1:0];
					lsbe_pkg::REG_ONE_DUTY: cur_one = cfg.data[lsbe_pkg::DUTY_W-1:0];
					lsbe_pkg::REG_ZERO_DUTY: cur_zero = cfg.data[lsbe_pkg::DUTY_W-1:0];
					default: ;
				endcase
			end
			if (bits.valid && bits.ready) begin
				got_slot = {bits.duty, bits.last_bit, bits.pixel_color};
				if (pending_slots.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("Unexpected bit slot: duty %0d last %0b color %06h",
							got_slot.duty, got_slot.last_bit, got_slot.color);
					end
				end else begin
					want_slot = pending_slots.pop_front();
					slots_checked++;
					if (got_slot.duty !== want_slot.duty
							|| got_slot.last_bit !== want_slot.last_bit
							|| got_slot.color !== want_slot.color) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"Bit slot mismatch: expected duty %0d last %0b",
								" color %06h, got duty %0d last %0b color %06h"},
								want_slot.duty, want_slot.last_bit, want_slot.color,
								got_slot.duty, got_slot.last_bit, got_slot.color);
						end
					end
				end
			end
			if (pix.valid && pix.ready) begin
				pixels_accepted++;
				if (int'(pix.pixel_index) < STRIP_LEN) begin
					pix_color = expected_grb(pix.frame_step, pix.chase_phase,
						pix.pixel_index);
					for (int k = 0; k < SLOTS; k++) begin
						pending_slots.push_back({
							pix_color[lsbe_pkg::COLOR_W-1-k] ? cur_one : cur_zero,
							k == SLOTS - 1, pix_color});
					end
				end
			end
		end
	end

	initial begin
		bits.ready <= 1'b0;
		forever begin
			@(posedge clk);
			bits.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out with %0d bit slots outstanding.", pending_slots.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_pixel(input logic [lsbe_pkg::STEP_W-1:0] step,
			input logic [lsbe_pkg::PHASE_W-1:0] phase,
			input logic [lsbe_pkg::PIX_W-1:0] index);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.frame_step <= step;
		pix.chase_phase <= phase;
		pix.pixel_index <= index;
		@(posedge clk);
		while (!pix.ready) begin
			@(posedge clk);
		end
	endtask

	task automatic put_reg(input lsbe_pkg::reg_idx_t idx,
			input logic [lsbe_pkg::COLOR_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) begin
			@(posedge clk);
		end
	endtask

	// Upper data bits are filled with noise, since each register keeps only its own width.
	task automatic load_settings(input logic [lsbe_pkg::MODE_W-1:0] mode,
			input logic [lsbe_pkg::COLOR_W-1:0] base,
			input logic [lsbe_pkg::DUTY_W-1:0] one,
			input logic [lsbe_pkg::DUTY_W-1:0] zero);
		put_reg(lsbe_pkg::REG_EFFECT_MODE, {21'($urandom), mode});
		put_reg(lsbe_pkg::REG_BASE_COLOR, base);
		put_reg(lsbe_pkg::REG_ONE_DUTY, {16'($urandom), one});
		put_reg(lsbe_pkg::REG_ZERO_DUTY, {16'($urandom), zero});
		cfg.valid <= 1'b0;
		settings_loaded++;
	endtask

	// The last pixel may have been accepted at this very edge, so the check
	// starts at the next edge, once its slots are queued.
	task automatic wait_drained();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending_slots.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic test_reset_defaults();
		send_pixel(11'd0, 2'd0, 6'd0);
		send_pixel(11'd1279, 2'd3, 6'd63);
		wait_drained();
	endtask

	task automatic test_wipe();
		load_settings(lsbe_pkg::MODE_WIPE, 24'hFFFFFF, 8'hFF, 8'h00);
		send_pixel(11'd0, 2'd0, 6'd0);
		send_pixel(11'd0, 2'd1, 6'd1);
		send_pixel(11'd1279, 2'd2, 6'd63);
		send_pixel(11'd62, 2'd0, 6'd63);
		wait_drained();
	endtask

	task automatic test_rainbow();
		load_settings(lsbe_pkg::MODE_RAINBOW, 24'h000000, 8'h00, 8'hFF);
		send_pixel(11'd0, 2'd0, 6'd0);
		send_pixel(11'd85, 2'd0, 6'd0);
		send_pixel(11'd170, 2'd1, 6'd0);
		send_pixel(11'd1279, 2'd3, 6'd63);
		wait_drained();
	endtask

	task automatic test_rainbow_cycle();
		load_settings(lsbe_pkg::MODE_CYCLE, 24'h5A5A5A, 8'hA5, 8'h5A);
		send_pixel(11'd0, 2'd0, 6'd0);
		send_pixel(11'd1279, 2'd1, 6'd63);
		wait_drained();
	endtask

	task automatic test_chase();
		load_settings(lsbe_pkg::MODE_CHASE, 24'hA5C3F0, 8'd200, 8'd7);
		send_pixel(11'd5, 2'd0, 6'd0);
		send_pixel(11'd5, 2'd1, 6'd0);
		send_pixel(11'd5, 2'd2, 6'd62);
		send_pixel(11'd5, 2'd3, 6'd63);
		wait_drained();
	endtask

	task automatic test_chase_rainbow();
		load_settings(lsbe_pkg::MODE_CHASE_RB, 24'hFFFFFF, lsbe_pkg::RST_ONE_DUTY,
			lsbe_pkg::RST_ZERO_DUTY);
		send_pixel(11'd0, 2'd0, 6'd0);
		send_pixel(11'd255, 2'd0, 6'd63);
		send_pixel(11'd1279, 2'd2, 6'd2);
		send_pixel(11'd10, 2'd3, 6'd3);
		wait_drained();
	endtask

	task automatic test_unused_modes();
		load_settings(3'd5, 24'hFFFFFF, 8'hFF, 8'h00);
		send_pixel(11'd0, 2'd0, 6'd0);
		wait_drained();
		load_settings(3'd6, 24'hFFFFFF, 8'h12, 8'h34);
		send_pixel(11'd1279, 2'd3, 6'd63);
		wait_drained();
		load_settings(3'd7, 24'hFFFFFF, 8'h00, 8'hFF);
		send_pixel(11'd100, 2'd1, 6'd1);
		wait_drained();
	endtask

	task automatic test_random();
		int send_mix[4] = '{0, 79, 0, 11};
		int stall_mix[4] = '{0, 0, 79, 11};
		logic [lsbe_pkg::MODE_W-1:0] mode;
		logic [lsbe_pkg::COLOR_W-1:0] base;
		logic [lsbe_pkg::DUTY_W-1:0] one;
		logic [lsbe_pkg::DUTY_W-1:0] zero;
		logic [lsbe_pkg::STEP_W-1:0] step;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_mix[ph];
			stall_pct = stall_mix[ph];
			for (int s = 0; s < 4; s++) begin
				case ((ph * 4 + s) % 5)
					0: mode = lsbe_pkg::MODE_WIPE;
					1: mode = lsbe_pkg::MODE_RAINBOW;
					2: mode = lsbe_pkg::MODE_CYCLE;
					3: mode = lsbe_pkg::MODE_CHASE;
					default: mode = lsbe_pkg::MODE_CHASE_RB;
				endcase
				if ($urandom_range(0, 7) == 0) begin
					mode = 3'($urandom_range(5, 7));
				end
				case ($urandom_range(0, 3))
					0: base = 24'h000000;
					1: base = 24'hFFFFFF;
					default: base = 24'($urandom);
				endcase
				one = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
				zero = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
				load_settings(mode, base, one, zero);
				for (int n = 0; n < 30; n++) begin
					if ($urandom_range(0, 2) == 0) begin
						step = 11'($urandom_range(0, 63));
					end else if ($urandom_range(0, 9) == 0) begin
						step = 11'($urandom);
					end else begin
						step = 11'($urandom_range(0, 1279));
					end
					send_pixel(step, 2'($urandom), 6'($urandom));
				end
				wait_drained();
			end
		end
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		arst_n <= 1'b0;
		pix.valid <= 1'b0;
		pix.frame_step <= '0;
		pix.chase_phase <= '0;
		pix.pixel_index <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= lsbe_pkg::REG_EFFECT_MODE;
		cfg.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_wipe();
		test_rainbow();
		test_rainbow_cycle();
		test_chase();
		test_chase_rainbow();
		test_unused_modes();
		test_random();

		wait_drained();
		repeat (8) @(posedge clk);
		fail_count += pending_slots.size();
		$display("Checked %0d bit slots from %0d pixels under %0d register settings,",
			slots_checked, pixels_accepted, settings_loaded);
		$display("covering all five effects, the unused modes and four idling mixes.");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/lsbe_pkg.sv
sv/lsbe_if.sv
sv/lsbe_front.sv
sv/lsbe_queue.sv
sv/lsbe_back.sv
sv/led_strip_effect_bit_encoder_top.sv
tb/led_strip_effect_bit_encoder_top_tb.sv
